// ===== design/assert_macros.svh =====
// Assertion macros shared by the tracker modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MFTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFTT_ASSERT_IMP(lbl, ante, cons, msg)
`define MFTT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/mftt_pkg.sv =====
package mftt_pkg;

    // MIDI message kinds, taken from the upper nibble of the status byte.
    localparam logic [3:0] KIND_PITCH_BEND = 4'hE;
    localparam logic [3:0] KIND_CONTROL    = 4'hB;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;

    localparam logic [13:0] FADER_MAX   = 14'd16383;
    localparam logic [7:0]  DIAL_FIRST  = 8'd16;
    localparam logic [7:0]  TOUCH_FIRST = 8'd104;
    localparam logic [15:0] MIN_DELAY   = 16'd50;
    localparam logic [15:0] RESET_DELAY = 16'd300;

    localparam int VALUE_W = 14;

    // Commands passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_FADER = 2'd0,
        OP_DIAL  = 2'd1,
        OP_TOUCH = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    localparam int OP_W = 2;

    typedef struct packed {
        logic       func;
        logic [7:0] status_byte;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [7:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]  channel_index;
        logic [13:0] fader_position;
        logic [7:0]  dial_value;
        logic        active_flag;
        logic        seen_flag;
        logic        hold_request;
        logic        last_channel;
    } result_t;

endpackage

// ===== design/mftt_stream_if.sv =====
interface mftt_item_if;
    logic           valid;
    logic           ready;
    mftt_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mftt_result_if;
    logic             valid;
    logic             ready;
    mftt_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mftt_front.sv =====
// Classifies incoming words into back-end commands and drops ignored messages.
module mftt_front #(
    parameter int CHANNELS = 8,
    parameter int CH_W     = 3
) (
    mftt_item_if.sink              items,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output mftt_pkg::op_t          cmd_op,
    output logic [CH_W-1:0]        cmd_chan,
    output logic [mftt_pkg::VALUE_W-1:0] cmd_value
);

    logic [3:0]  kind;
    logic [3:0]  nibble;
    logic [14:0] bend_raw;
    logic [8:0]  d1_wide;
    logic        is_bend;
    logic        is_dial;
    logic        is_touch;
    logic        keep;

    assign kind     = items.payload.status_byte[7:4];
    assign nibble   = items.payload.status_byte[3:0];
    assign d1_wide  = {1'b0, items.payload.data_first};
    assign bend_raw = {items.payload.data_second, 7'd0}
                    | {7'd0, items.payload.data_first};

    assign is_bend  = (kind == mftt_pkg::KIND_PITCH_BEND)
                   && ({1'b0, nibble} < 5'(CHANNELS));
    assign is_dial  = (kind == mftt_pkg::KIND_CONTROL)
                   && (d1_wide >= {1'b0, mftt_pkg::DIAL_FIRST})
                   && (d1_wide < ({1'b0, mftt_pkg::DIAL_FIRST} + 9'(CHANNELS)));
    assign is_touch = ((kind == mftt_pkg::KIND_NOTE_ON) || (kind == mftt_pkg::KIND_NOTE_OFF))
                   && (d1_wide >= {1'b0, mftt_pkg::TOUCH_FIRST})
                   && (d1_wide < ({1'b0, mftt_pkg::TOUCH_FIRST} + 9'(CHANNELS)));

    always_comb
    begin
        keep      = 1'b0;
        cmd_op    = mftt_pkg::OP_TICK;
        cmd_chan  = '0;
        cmd_value = {6'd0, items.payload.elapsed_ms};
        if (items.payload.func)
        begin
            keep = 1'b1;
        end
        else if (is_bend)
        begin
            keep     = 1'b1;
            cmd_op   = mftt_pkg::OP_FADER;
            cmd_chan = CH_W'(nibble);
            // Values above the 14-bit range saturate at full scale.
            cmd_value = bend_raw[14] ? mftt_pkg::FADER_MAX : bend_raw[13:0];
        end
        else if (is_dial)
        begin
            keep      = 1'b1;
            cmd_op    = mftt_pkg::OP_DIAL;
            cmd_chan  = CH_W'(items.payload.data_first - mftt_pkg::DIAL_FIRST);
            cmd_value = {6'd0, items.payload.data_second};
        end
        else if (is_touch)
        begin
            keep      = 1'b1;
            cmd_op    = mftt_pkg::OP_TOUCH;
            cmd_chan  = CH_W'(items.payload.data_first - mftt_pkg::TOUCH_FIRST);
            cmd_value = {13'd0, (kind == mftt_pkg::KIND_NOTE_ON)
                                && (items.payload.data_second != 8'd0)};
        end
    end

    assign items.ready = cmd_ready;
    assign cmd_valid   = items.valid && keep;

endmodule

// ===== design/mftt_queue.sv =====
// Small circular command queue between the front and back ends.
module mftt_queue #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/mftt_back.sv =====
`include "assert_macros.svh"

// Executes commands: updates channel state and runs the tick scan.
module mftt_back #(
    parameter int CHANNELS = 8,
    parameter int CH_W     = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  mftt_pkg::op_t                cmd_op,
    input  logic [CH_W-1:0]              cmd_chan,
    input  logic [mftt_pkg::VALUE_W-1:0] cmd_value,
    input  logic                         hold_enable,
    input  logic [15:0]                  release_delay_ms,
    mftt_result_if.source                results
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CH_W-1:0]   scan_reg, scan_next;
    logic [7:0]        elapsed_reg, elapsed_next;
    logic              out_valid_reg, out_valid_next;
    mftt_pkg::result_t result_reg;

    logic [13:0]         fader_reg [CHANNELS];
    logic [7:0]          dial_reg [CHANNELS];
    logic [15:0]         countdown_reg [CHANNELS];
    logic [CHANNELS-1:0] touch_reg;
    logic [CHANNELS-1:0] seen_reg;
    logic [CHANNELS-1:0] changed_reg;
    logic [CHANNELS-1:0] moving_reg;

    logic [CH_W-1:0] addr;
    logic            cmd_pop;
    logic            slot_free;
    logic            scan_step;
    logic            scan_last;
    logic [15:0]     cd_cur;
    logic [15:0]     countdown_next;
    logic            end_move;
    logic            hold;
    logic [15:0]     eff_delay;
    logic            touch_now;
    logic            touch_drop;
    logic            in_scan;
    logic            out_hold;

    // Scan and command execution never overlap, so one index serves both.
    assign addr      = (state_reg == ST_SCAN) ? scan_reg : cmd_chan;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_pop   = cmd_valid && cmd_ready;
    assign slot_free = !out_valid_reg || results.ready;
    assign scan_step = (state_reg == ST_SCAN) && slot_free;
    assign scan_last = (scan_reg == CH_W'(CHANNELS - 1));

    assign eff_delay = (release_delay_ms < mftt_pkg::MIN_DELAY) ? mftt_pkg::MIN_DELAY
                                                                : release_delay_ms;

    assign cd_cur         = countdown_reg[addr];
    assign countdown_next = (cd_cur > {8'd0, elapsed_reg}) ? cd_cur - {8'd0, elapsed_reg}
                                                           : 16'd0;
    assign end_move       = moving_reg[addr] && (countdown_next == 16'd0);
    assign hold           = end_move && hold_enable && !touch_reg[addr] && changed_reg[addr];

    assign touch_now  = cmd_value[0];
    assign touch_drop = hold_enable && touch_reg[addr] && !touch_now && changed_reg[addr];

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        elapsed_next   = elapsed_reg;
        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = scan_step;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop && (cmd_op == mftt_pkg::OP_TICK))
                begin
                    state_next   = ST_SCAN;
                    scan_next    = '0;
                    elapsed_next = cmd_value[7:0];
                end
            end
            ST_SCAN:
            begin
                if (scan_step)
                begin
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            touch_reg     <= '0;
            seen_reg      <= '0;
            changed_reg   <= '0;
            moving_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                fader_reg[i]     <= '0;
                dial_reg[i]      <= '0;
                countdown_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cmd_pop)
            begin
                case (cmd_op)
                    mftt_pkg::OP_FADER:
                    begin
                        fader_reg[addr]     <= cmd_value;
                        seen_reg[addr]      <= 1'b1;
                        changed_reg[addr]   <= 1'b1;
                        moving_reg[addr]    <= 1'b1;
                        countdown_reg[addr] <= eff_delay;
                    end
                    mftt_pkg::OP_DIAL:
                    begin
                        dial_reg[addr] <= cmd_value[7:0];
                    end
                    mftt_pkg::OP_TOUCH:
                    begin
                        touch_reg[addr] <= touch_now;
                        if (touch_now)
                        begin
                            seen_reg[addr] <= 1'b1;
                        end
                        if (touch_drop)
                        begin
                            countdown_reg[addr] <= eff_delay;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (scan_step)
            begin
                countdown_reg[addr] <= countdown_next;
                if (end_move)
                begin
                    moving_reg[addr] <= 1'b0;
                end
                if (hold)
                begin
                    changed_reg[addr] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        if (scan_step)
        begin
            result_reg.channel_index  <= 3'(addr);
            result_reg.fader_position <= fader_reg[addr];
            result_reg.dial_value     <= dial_reg[addr];
            result_reg.active_flag    <= touch_reg[addr] || (moving_reg[addr] && !end_move);
            result_reg.seen_flag      <= seen_reg[addr];
            result_reg.hold_request   <= hold;
            result_reg.last_channel   <= scan_last;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = result_reg;

    assign in_scan  = (state_reg == ST_SCAN);
    assign out_hold = out_valid_reg && result_reg.hold_request;

    `MFTT_ASSERT_IMP(a_no_pop_in_scan, in_scan, !cmd_pop, "command taken during scan")
    `MFTT_ASSERT_NXT(a_scan_holds, in_scan && !slot_free, $stable(scan_reg), "scan moved on stall")
    `MFTT_ASSERT_NXT(a_last_ends_scan, scan_step && scan_last, !in_scan, "scan did not end")
    `MFTT_ASSERT_IMP(a_hold_inactive, out_hold, !result_reg.active_flag, "hold while active")

endmodule

// ===== design/midi_fader_touch_tracker_core.sv =====
// Motor-fader touch tracker core.
// The items channel takes one word per MIDI message (func 0) or time tick (func 1).
// Pitch bend, dial controllers and touch notes update per-channel state and
// produce no result. A tick produces one result word per channel, channel 0
// first, with last_channel set on the final one.
// A front end classifies each word in the cycle it is accepted and drops
// messages that are ignored; a four-entry command queue decouples it from the
// back end, so words are accepted at one per cycle until the queue fills.
// The back end executes a MIDI command as it dequeues it. A dequeued tick moves
// it into a scan of the channels over the single shared channel-update path,
// during which it takes no further command; each result word is registered
// in an output register that the scan fills, channel by channel.
// When the receiver stalls, the result register holds its word, the scan
// pauses, and the queue keeps taking words until it is full.
// Reset clears all channel state and restores hold_enable to 1 and
// release_delay_ms to 300; there is no clearing pass.
// The APB port holds hold_enable at address 0 and release_delay_ms at address 4.
// Writes complete in the access cycle and pready is always high; write only
// while the block is idle.
module midi_fader_touch_tracker_core #(
    parameter int CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mftt_item_if.sink   items,
    mftt_result_if.source results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int CMD_W       = mftt_pkg::OP_W + CH_W + mftt_pkg::VALUE_W;

    // Register index, taken from address bit 2.
    localparam logic REG_HOLD_ENABLE   = 1'b0;
    localparam logic REG_RELEASE_DELAY = 1'b1;

    logic        hold_enable_reg;
    logic [15:0] release_delay_reg;
    logic        cfg_write;

    logic                         front_valid;
    logic                         front_ready;
    mftt_pkg::op_t                front_op;
    logic [CH_W-1:0]              front_chan;
    logic [mftt_pkg::VALUE_W-1:0] front_value;

    logic             back_valid;
    logic             back_ready;
    logic [CMD_W-1:0] back_data;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_enable_reg   <= 1'b1;
            release_delay_reg <= mftt_pkg::RESET_DELAY;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_HOLD_ENABLE:   hold_enable_reg   <= pwdata[0];
                REG_RELEASE_DELAY: release_delay_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HOLD_ENABLE:   prdata = {31'd0, hold_enable_reg};
            REG_RELEASE_DELAY: prdata = {16'd0, release_delay_reg};
            default:           prdata = '0;
        endcase
    end

    mftt_front #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_front (
        .items     (items),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd_op    (front_op),
        .cmd_chan  (front_chan),
        .cmd_value (front_value)
    );

    mftt_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  ({front_op, front_chan, front_value}),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_data)
    );

    mftt_back #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (back_valid),
        .cmd_ready        (back_ready),
        .cmd_op           (mftt_pkg::op_t'(back_data[CMD_W-1 -: mftt_pkg::OP_W])),
        .cmd_chan         (back_data[mftt_pkg::VALUE_W +: CH_W]),
        .cmd_value        (back_data[mftt_pkg::VALUE_W-1:0]),
        .hold_enable      (hold_enable_reg),
        .release_delay_ms (release_delay_reg),
        .results          (results)
    );

endmodule
